// ----- rtl/xrdu_pkg.sv -----
// ----------------------------------------------------------------------------
// xrdu_pkg
// Constants and types shared by the xorshift random draw unit.
// ----------------------------------------------------------------------------
package xrdu_pkg;

  // xorshift64* output multiplier, also used on the seed
  localparam logic [63:0] MulStar    = 64'h2545_f491_4f6c_dd1d;
  // added to the scaled seed before mixing
  localparam logic [63:0] SeedOffset = 64'h0000_0000_9e37_79b9;
  // stands in for a zero generator state
  localparam logic [63:0] ZeroAlt    = 64'h0123_4567_dead_beef;
  // splitmix64 finalizer multipliers
  localparam logic [63:0] MixK1      = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MixK2      = 64'h94d0_49bb_1331_11eb;
  // probability of one, scaled by 2^24
  localparam logic [24:0] ProbOne    = 25'h100_0000;

  // APB register map
  localparam int unsigned AddrW   = 3;
  localparam logic        RegSeed = 1'b0;

  // request kinds
  typedef enum logic [1:0] {
    OP_RAW    = 2'd0,
    OP_FRAC   = 2'd1,
    OP_RANGE  = 2'd2,
    OP_CHANCE = 2'd3
  } op_e;

  // which 64-bit multiply the sequencer is running
  typedef enum logic [1:0] {
    MK_SEED = 2'd0,
    MK_MIX1 = 2'd1,
    MK_MIX2 = 2'd2,
    MK_OUT  = 2'd3
  } mul_kind_e;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE = 7'b000_0001,
    ST_MUL0 = 7'b000_0010,
    ST_MUL1 = 7'b000_0100,
    ST_MUL2 = 7'b000_1000,
    ST_MUL3 = 7'b001_0000,
    ST_DIV  = 7'b010_0000,
    ST_FIN  = 7'b100_0000
  } state_e;

endpackage

// ----- rtl/xorshift_random_draw_unit.sv -----
// ----------------------------------------------------------------------------
// xorshift_random_draw_unit
// xorshift64* draw unit with splitmix64 reseed, fraction, range and chance.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                      payload
//  in        to unit    in_valid_i / in_stall_o        op_i, range_low_i,
//                                                      range_high_i, probability_i
//  out       from unit  out_valid_o / out_stall_i      raw_draw_o, fraction_o,
//                                                      ranged_value_o, hit_o
//  cfg       to unit    psel/penable/pwrite, pready=1  paddr, pwdata, prdata
//
//  All 64-bit products run on one 32x32 multiplier as three partial products
//  and a final sum. A range draw adds the one-bit-a-cycle restoring remainder
//  unit unless its span wraps to zero. Requests answered without drawing skip
//  the multiplier. A seed write (and the exit from reset, which seeds from
//  zero) runs three multiplies with input stalled. A finished result waits in
//  the output register while the next request is taken; the sequencer holds in
//  its final state until it frees.
// ----------------------------------------------------------------------------
module xorshift_random_draw_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 op_i,
  input  logic signed [31:0]         range_low_i,
  input  logic signed [31:0]         range_high_i,
  input  logic [24:0]                probability_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [31:0]                raw_draw_o,
  output logic [23:0]                fraction_o,
  output logic signed [31:0]         ranged_value_o,
  output logic                       hit_o,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [xrdu_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  xrdu_pkg::state_e    state_q;
  xrdu_pkg::mul_kind_e kind_q;
  xrdu_pkg::op_e       op_q;

  logic [31:0] seed_q;
  logic [63:0] gen_q;
  logic [63:0] z_q;
  logic [63:0] sum_q;
  logic [63:0] prod_q;
  logic [31:0] lo_q;
  logic [31:0] span_q;
  logic [23:0] prob_q;
  logic [31:0] pend_q;
  logic [31:0] rem_q;
  logic [31:0] dvd_q;
  logic [4:0]  cnt_q;

  logic        out_valid_q;
  logic [31:0] raw_q;
  logic [23:0] frac_q;
  logic [31:0] ranged_q;
  logic        hit_q;

  // xorshift state step
  function automatic logic [63:0] xs_step(input logic [63:0] x);
    logic [63:0] a;
    logic [63:0] b;
    a = x ^ (x >> 12);
    b = a ^ (a << 25);
    return b ^ (b >> 27);
  endfunction

  // configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == xrdu_pkg::RegSeed);
  assign prdata = (paddr[2] == xrdu_pkg::RegSeed) ? seed_q : 32'd0;

  // handshakes; a seed write holds off the request taken in the same cycle
  logic in_xfer;
  logic out_free;
  assign in_stall_o = (state_q != xrdu_pkg::ST_IDLE) || cfg_wr;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // constant for the current multiply
  logic [63:0] mul_k;
  always_comb begin
    case (kind_q)
      xrdu_pkg::MK_MIX1: mul_k = xrdu_pkg::MixK1;
      xrdu_pkg::MK_MIX2: mul_k = xrdu_pkg::MixK2;
      default:           mul_k = xrdu_pkg::MulStar;
    endcase
  end

  // shared 32x32 multiplier, operands chosen by the partial product step
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  always_comb begin
    mul_a = z_q[31:0];
    mul_b = mul_k[31:0];
    if (state_q == xrdu_pkg::ST_MUL1) begin
      mul_a = z_q[63:32];
    end else if (state_q == xrdu_pkg::ST_MUL2) begin
      mul_b = mul_k[63:32];
    end
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // low 64 bits of the full product, and values derived from it
  logic [63:0] mul_r;
  logic [63:0] seed_t;
  logic [63:0] mix_s;
  logic [31:0] draw;
  assign mul_r  = {sum_q[63:32] + prod_q[31:0], sum_q[31:0]};
  assign seed_t = mul_r + xrdu_pkg::SeedOffset;
  assign mix_s  = mul_r ^ (mul_r >> 31);
  assign draw   = mul_r[63:32];

  // remainder step
  logic [32:0] div_t;
  logic [31:0] rem_next;
  assign div_t    = {rem_q, dvd_q[31]};
  assign rem_next = (div_t >= {1'b0, span_q}) ? 32'(div_t - {1'b0, span_q}) : div_t[31:0];

  // next generator state on a draw
  logic [63:0] gen_next;
  assign gen_next = xs_step(gen_q);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xrdu_pkg::ST_MUL0;
      kind_q  <= xrdu_pkg::MK_SEED;
      seed_q  <= 32'd0;
      z_q     <= 64'd0;
    end else if (cfg_wr) begin
      // reseed: scale the seed first
      seed_q  <= pwdata;
      z_q     <= {32'd0, pwdata};
      kind_q  <= xrdu_pkg::MK_SEED;
      state_q <= xrdu_pkg::ST_MUL0;
    end else begin
      case (state_q)
        xrdu_pkg::ST_IDLE: begin
          if (in_xfer) begin
            case (xrdu_pkg::op_e'(op_i))
              xrdu_pkg::OP_RANGE: begin
                if (range_high_i <= range_low_i) begin
                  state_q <= xrdu_pkg::ST_FIN;
                end else begin
                  z_q     <= gen_next;
                  kind_q  <= xrdu_pkg::MK_OUT;
                  state_q <= xrdu_pkg::ST_MUL0;
                end
              end
              xrdu_pkg::OP_CHANCE: begin
                if (probability_i == 25'd0 || probability_i >= xrdu_pkg::ProbOne) begin
                  state_q <= xrdu_pkg::ST_FIN;
                end else begin
                  z_q     <= gen_next;
                  kind_q  <= xrdu_pkg::MK_OUT;
                  state_q <= xrdu_pkg::ST_MUL0;
                end
              end
              default: begin
                z_q     <= gen_next;
                kind_q  <= xrdu_pkg::MK_OUT;
                state_q <= xrdu_pkg::ST_MUL0;
              end
            endcase
          end
        end
        xrdu_pkg::ST_MUL0: state_q <= xrdu_pkg::ST_MUL1;
        xrdu_pkg::ST_MUL1: state_q <= xrdu_pkg::ST_MUL2;
        xrdu_pkg::ST_MUL2: state_q <= xrdu_pkg::ST_MUL3;
        xrdu_pkg::ST_MUL3: begin
          case (kind_q)
            xrdu_pkg::MK_SEED: begin
              z_q     <= seed_t ^ (seed_t >> 30);
              kind_q  <= xrdu_pkg::MK_MIX1;
              state_q <= xrdu_pkg::ST_MUL0;
            end
            xrdu_pkg::MK_MIX1: begin
              z_q     <= mul_r ^ (mul_r >> 27);
              kind_q  <= xrdu_pkg::MK_MIX2;
              state_q <= xrdu_pkg::ST_MUL0;
            end
            xrdu_pkg::MK_MIX2: state_q <= xrdu_pkg::ST_IDLE;
            default: begin
              if (op_q == xrdu_pkg::OP_RANGE && span_q != 32'd0) begin
                state_q <= xrdu_pkg::ST_DIV;
              end else begin
                state_q <= xrdu_pkg::ST_FIN;
              end
            end
          endcase
        end
        xrdu_pkg::ST_DIV: begin
          if (cnt_q == 5'd0) begin
            state_q <= xrdu_pkg::ST_FIN;
          end
        end
        xrdu_pkg::ST_FIN: begin
          if (out_free) begin
            state_q <= xrdu_pkg::ST_IDLE;
          end
        end
        default: state_q <= xrdu_pkg::ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    // partial products and their running sum
    case (state_q)
      xrdu_pkg::ST_MUL0: prod_q <= mul_p;
      xrdu_pkg::ST_MUL1: begin
        sum_q  <= prod_q;
        prod_q <= mul_p;
      end
      xrdu_pkg::ST_MUL2: begin
        sum_q[63:32] <= sum_q[63:32] + prod_q[31:0];
        prod_q       <= mul_p;
      end
      default: ;
    endcase

    // generator state: seeded at the end of a reseed, stepped on a draw
    if (state_q == xrdu_pkg::ST_MUL3 && kind_q == xrdu_pkg::MK_MIX2) begin
      gen_q <= (mix_s == 64'd0) ? xrdu_pkg::ZeroAlt : mix_s;
    end else if (in_xfer && !cfg_wr) begin
      if (!((xrdu_pkg::op_e'(op_i) == xrdu_pkg::OP_RANGE && range_high_i <= range_low_i) ||
            (xrdu_pkg::op_e'(op_i) == xrdu_pkg::OP_CHANCE &&
             (probability_i == 25'd0 || probability_i >= xrdu_pkg::ProbOne)))) begin
        gen_q <= gen_next;
      end
    end

    // request capture and the answers that need no draw
    if (in_xfer) begin
      op_q   <= xrdu_pkg::op_e'(op_i);
      lo_q   <= range_low_i;
      span_q <= 32'(range_high_i - range_low_i + 32'sd1);
      prob_q <= probability_i[23:0];
      if (xrdu_pkg::op_e'(op_i) == xrdu_pkg::OP_RANGE) begin
        pend_q <= range_low_i;
      end else if (probability_i >= xrdu_pkg::ProbOne) begin
        pend_q <= 32'd1;
      end else begin
        pend_q <= 32'd0;
      end
    end

    // shape the draw
    if (state_q == xrdu_pkg::ST_MUL3 && kind_q == xrdu_pkg::MK_OUT) begin
      case (op_q)
        xrdu_pkg::OP_RAW:   pend_q <= draw;
        xrdu_pkg::OP_FRAC:  pend_q <= {8'd0, draw[31:8]};
        xrdu_pkg::OP_RANGE: pend_q <= lo_q + draw;
        default:            pend_q <= {31'd0, (draw[31:8] < prob_q)};
      endcase
      rem_q <= 32'd0;
      dvd_q <= draw;
      cnt_q <= 5'd31;
    end

    // one remainder bit per cycle
    if (state_q == xrdu_pkg::ST_DIV) begin
      rem_q <= rem_next;
      dvd_q <= {dvd_q[30:0], 1'b0};
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        pend_q <= lo_q + rem_next;
      end
    end

    // output payload
    if (state_q == xrdu_pkg::ST_FIN && out_free) begin
      raw_q    <= (op_q == xrdu_pkg::OP_RAW)    ? pend_q       : 32'd0;
      frac_q   <= (op_q == xrdu_pkg::OP_FRAC)   ? pend_q[23:0] : 24'd0;
      ranged_q <= (op_q == xrdu_pkg::OP_RANGE)  ? pend_q       : 32'd0;
      hit_q    <= (op_q == xrdu_pkg::OP_CHANCE) ? pend_q[0]    : 1'b0;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == xrdu_pkg::ST_FIN && out_free && !cfg_wr) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign raw_draw_o     = raw_q;
  assign fraction_o     = frac_q;
  assign ranged_value_o = ranged_q;
  assign hit_o          = hit_q;

endmodule

// ----- tb/xorshift_random_draw_unit_test.sv -----
// ----------------------------------------------------------------------------
// xorshift_random_draw_unit_test
// Self-checking bench for the xorshift64* draw unit. A scoreboard keeps its
// own generator state, reseeds it on every seed write and works out each
// request's result. Results are compared field by field in order. Requests
// cover every kind and bound case, then random traffic under several seeds
// with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module xorshift_random_draw_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  // one expected result transfer
  typedef struct {
    logic [31:0]        raw;
    logic [23:0]        frac;
    logic signed [31:0] ranged;
    logic               hit;
  } draw_result_t;

  // generator copy and the results it still owes
  class draw_ledger;
    logic [63:0]  gen_state;
    draw_result_t owed[$];
    int           errors;

    function new();
      errors = 0;
      reseed(32'd0);
    endfunction

    // splitmix64 finalizer over the scaled seed
    function void reseed(input logic [31:0] seed);
      logic [63:0] z;
      z = {32'd0, seed} * xrdu_pkg::MulStar + xrdu_pkg::SeedOffset;
      z = (z ^ (z >> 30)) * xrdu_pkg::MixK1;
      z = (z ^ (z >> 27)) * xrdu_pkg::MixK2;
      z = z ^ (z >> 31);
      gen_state = (z == 64'd0) ? xrdu_pkg::ZeroAlt : z;
    endfunction

    // one xorshift64* step, high word of the scrambled product
    function logic [31:0] next_draw();
      logic [63:0] x;
      logic [63:0] prod;
      x = gen_state;
      x = x ^ (x >> 12);
      x = x ^ (x << 25);
      x = x ^ (x >> 27);
      gen_state = x;
      prod = x * xrdu_pkg::MulStar;
      return prod[63:32];
    endfunction

    function void note_request(input xrdu_pkg::op_e op, input logic signed [31:0] lo,
                               input logic signed [31:0] hi, input logic [24:0] prob);
      draw_result_t r;
      logic [31:0]  span;
      logic [31:0]  d;
      r = '{default: '0};
      case (op)
        xrdu_pkg::OP_RAW: r.raw = next_draw();
        xrdu_pkg::OP_FRAC: begin
          d = next_draw();
          r.frac = d[31:8];
        end
        xrdu_pkg::OP_RANGE: begin
          // a range with hi not above lo answers lo without drawing
          if (hi <= lo) begin
            r.ranged = lo;
          end else begin
            span = hi - lo + 32'd1;
            d = next_draw();
            // a span that wraps to zero is the full int range
            r.ranged = (span == 32'd0) ? lo + d : lo + (d % span);
          end
        end
        default: begin
          if (prob == '0) begin
            r.hit = 1'b0;
          end else if (prob >= xrdu_pkg::ProbOne) begin
            r.hit = 1'b1;
          end else begin
            d = next_draw();
            r.hit = (d[31:8] < prob);
          end
        end
      endcase
      owed.push_back(r);
    endfunction

    function void check_result(input logic [31:0] raw, input logic [23:0] frac,
                               input logic [31:0] ranged, input logic hit);
      draw_result_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result raw %h frac %h ranged %h hit %b",
                 $time, raw, frac, ranged, hit);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (e.raw !== raw) begin
        $display("%0t: raw_draw expected %h actual %h", $time, e.raw, raw);
        errors++;
      end
      if (e.frac !== frac) begin
        $display("%0t: fraction expected %h actual %h", $time, e.frac, frac);
        errors++;
      end
      if (e.ranged !== ranged) begin
        $display("%0t: ranged_value expected %h actual %h", $time, e.ranged, ranged);
        errors++;
      end
      if (e.hit !== hit) begin
        $display("%0t: hit expected %b actual %b", $time, e.hit, hit);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [1:0]                 op_i;
  logic signed [31:0]         range_low_i;
  logic signed [31:0]         range_high_i;
  logic [24:0]                probability_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [31:0]                raw_draw_o;
  logic [23:0]                fraction_o;
  logic signed [31:0]         ranged_value_o;
  logic                       hit_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [xrdu_pkg::AddrW-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  draw_ledger ledger = new();
  bit         idle_on = 1'b1;
  bit         hold_off_req = 1'b0;

  xorshift_random_draw_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .range_low_i    (range_low_i),
    .range_high_i   (range_high_i),
    .probability_i  (probability_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .raw_draw_o     (raw_draw_o),
    .fraction_o     (fraction_o),
    .ranged_value_o (ranged_value_o),
    .hit_o          (hit_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #4 clk_i = ~clk_i;

  // one request transfer; called at a rising edge, returns at the accepting edge
  task automatic send_request(input xrdu_pkg::op_e op, input logic [31:0] lo,
                              input logic [31:0] hi, input logic [24:0] prob);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    range_low_i   <= lo;
    range_high_i  <= hi;
    probability_i <= prob;
    do @(posedge clk_i); while (in_stall_o);
    ledger.note_request(op, lo, hi, prob);
  endtask

  // random request, biased towards narrow ranges and live probabilities
  task automatic send_random();
    int unsigned   pick;
    logic [31:0]   lo;
    logic [31:0]   hi;
    logic [24:0]   prob;
    xrdu_pkg::op_e op;
    op = xrdu_pkg::op_e'($urandom_range(0, 3));
    lo = $urandom;
    hi = $urandom;
    pick = $urandom_range(0, 9);
    case (pick)
      2, 3, 4, 5: hi = lo + $urandom_range(1, 1000);
      6: hi = lo;
      7: begin
        lo = 32'h8000_0000;
        hi = 32'h7fff_ffff;
      end
      8: hi = lo + ($urandom >> $urandom_range(0, 31));
      default: ;
    endcase
    pick = $urandom_range(0, 9);
    case (pick)
      0: prob = '0;
      1: prob = xrdu_pkg::ProbOne;
      2: prob = 25'($urandom);
      default: prob = 25'($urandom_range(1, xrdu_pkg::ProbOne - 1));
    endcase
    send_request(op, lo, hi, prob);
  endtask

  // random phase with stretches of idling and of back-to-back traffic
  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_random();
    end
    idle_on = 1'b1;
  endtask

  // stop offering and wait until every owed result has been taken
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ledger.owed.size() != 0) @(posedge clk_i);
  endtask

  // APB write: setup then access; indices 0 to 3 all reach the seed register
  task automatic write_reg(input logic [xrdu_pkg::AddrW-1:0] addr,
                           input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr[xrdu_pkg::AddrW-1:2] == xrdu_pkg::RegSeed) ledger.reseed(data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // result side: check each transfer, then draw the stall for the next
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        ledger.check_result(raw_draw_o, fraction_o, ranged_value_o, hit_o);
        stall_left = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (hold_off_req) begin
        hold_left    = 300;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // stimulus
  initial begin : request_source
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    op_i          <= xrdu_pkg::OP_RAW;
    range_low_i   <= '0;
    range_high_i  <= '0;
    probability_i <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: every kind, bound cases, under the reset seed
    send_request(xrdu_pkg::OP_RAW,    32'hffff_ffff, 32'h0000_0000, 25'h1ff_ffff);
    send_request(xrdu_pkg::OP_FRAC,   32'h0000_0000, 32'hffff_ffff, 25'h000_0000);
    send_request(xrdu_pkg::OP_RANGE,  32'd5,         32'd5,         '0);
    send_request(xrdu_pkg::OP_RANGE,  32'd10,        -32'sd10,      '0);
    send_request(xrdu_pkg::OP_RANGE,  32'h7fff_ffff, 32'h8000_0000, '0);
    send_request(xrdu_pkg::OP_RANGE,  32'h8000_0000, 32'h7fff_ffff, '0);
    send_request(xrdu_pkg::OP_RANGE,  32'h8000_0000, 32'h7fff_fffe, '0);
    send_request(xrdu_pkg::OP_RANGE,  32'h8000_0000, 32'h8000_0001, '0);
    send_request(xrdu_pkg::OP_RANGE,  32'h7fff_fffe, 32'h7fff_ffff, '0);
    send_request(xrdu_pkg::OP_RANGE,  -32'sd100,     32'd100,       '0);
    send_request(xrdu_pkg::OP_RANGE,  32'd0,         32'd1,         '0);
    send_request(xrdu_pkg::OP_RANGE,  32'h8000_0000, 32'hffff_fffe, '0);
    send_request(xrdu_pkg::OP_CHANCE, 32'd0,         32'd0,         25'd0);
    send_request(xrdu_pkg::OP_CHANCE, 32'd0,         32'd0,         xrdu_pkg::ProbOne);
    send_request(xrdu_pkg::OP_CHANCE, 32'd0,         32'd0,         25'h1ff_ffff);
    send_request(xrdu_pkg::OP_CHANCE, 32'd0,         32'd0,         25'd1);
    send_request(xrdu_pkg::OP_CHANCE, 32'd0,         32'd0,
                 xrdu_pkg::ProbOne - 25'd1);
    send_request(xrdu_pkg::OP_CHANCE, 32'd0,         32'd0,         25'h080_0000);
    send_request(xrdu_pkg::OP_RAW,    32'd0,         32'd0,         '0);
    send_request(xrdu_pkg::OP_FRAC,   32'd0,         32'd0,         '0);

    // write outside the map must leave the generator alone
    drain_results();
    write_reg(xrdu_pkg::AddrW'(4), $urandom);
    run_random(200);

    // all-ones seed, with a long output hold-off so the input backs up
    drain_results();
    write_reg('0, 32'hffff_ffff);
    hold_off_req = 1'b1;
    run_random(250);

    // zero seed written explicitly
    drain_results();
    write_reg('0, 32'h0000_0000);
    run_random(200);

    // random seeds; the first pauses mid-phase until all results are in
    drain_results();
    write_reg('0, $urandom);
    run_random(110);
    drain_results();
    run_random(110);
    for (int s = 0; s < 2; s++) begin
      drain_results();
      write_reg('0, $urandom);
      run_random(240);
    end

    // let any stray transfer show up before the verdict
    drain_results();
    repeat (60) @(posedge clk_i);
    if (ledger.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #4ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
